// ===== rtl/core/gsdn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdn_pkg
// Shared types and constants for the stick dead-zone normalizer.
// ----------------------------------------------------------------------------
package gsdn_pkg;

  localparam logic [14:0] FULL_SCALE   = 15'd32767;
  localparam logic [15:0] ONE_Q15      = 16'd32768;
  localparam logic [31:0] FULL_SQ      = 32'd1073676289;  // 32767 squared
  localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;

  localparam logic [0:0] REG_LEFT_DZ  = 1'b0;
  localparam logic [0:0] REG_RIGHT_DZ = 1'b1;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trig;
    logic [7:0]         right_trig;
  } sample_t;

  typedef struct packed {
    logic [15:0]        left_mag;
    logic signed [15:0] left_dir_x;
    logic signed [15:0] left_dir_y;
    logic [15:0]        right_mag;
    logic signed [15:0] right_dir_x;
    logic signed [15:0] right_dir_y;
    logic [15:0]        left_trig_norm;
    logic [15:0]        right_trig_norm;
  } result_t;

  typedef struct packed {
    logic [15:0]        mag;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [15:0]        trig_norm;
  } lane_out_t;

endpackage

// ===== rtl/core/gamepad_stick_deadzone_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_stick_deadzone_normalizer
// Each request runs through both lanes and the merge register to the done strobe.
// Throughput: one request per cycle; busy stays low, the lanes are fully
// pipelined (square-root and divider stages, one bit per stage).
// Reset: synchronous; clears the pipeline valids and loads the dead zones.
// The result is shown for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module gamepad_stick_deadzone_normalizer
  import gsdn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  sample_t     sample,
  output logic        done,
  output result_t     result,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [14:0] wr_data
);

  logic [14:0] left_dz, right_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= LEFT_DZ_RST;
      right_dz <= RIGHT_DZ_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LEFT_DZ:  left_dz  <= wr_data;
        REG_RIGHT_DZ: right_dz <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic      l_vld, r_vld;
  lane_out_t l_out, r_out;

  gsdn_lane u_left (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (accept),
    .x       (sample.left_x),
    .y       (sample.left_y),
    .dz      (left_dz),
    .trig    (sample.left_trig),
    .out_vld (l_vld),
    .out     (l_out)
  );

  gsdn_lane u_right (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (accept),
    .x       (sample.right_x),
    .y       (sample.right_y),
    .dz      (right_dz),
    .trig    (sample.right_trig),
    .out_vld (r_vld),
    .out     (r_out)
  );

  // merge: both lanes run in lockstep
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= l_vld && r_vld;
    end
    result.left_mag        <= l_out.mag;
    result.left_dir_x      <= l_out.dir_x;
    result.left_dir_y      <= l_out.dir_y;
    result.right_mag       <= r_out.mag;
    result.right_dir_x     <= r_out.dir_x;
    result.right_dir_y     <= r_out.dir_y;
    result.left_trig_norm  <= l_out.trig_norm;
    result.right_trig_norm <= r_out.trig_norm;
  end

endmodule

// ===== rtl/core/gsdn_sqrt_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdn_sqrt_pipe
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module gsdn_sqrt_pipe #(
  parameter int IN_W   = 62,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   in_val,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [IN_W/2-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int R_W   = IN_W / 2;
  localparam int REM_W = R_W + 2;

  logic              vld  [R_W+1];
  logic [IN_W-1:0]   val  [R_W+1];
  logic [REM_W-1:0]  rem  [R_W+1];
  logic [R_W-1:0]    root [R_W+1];
  logic [SIDE_W-1:0] side [R_W+1];

  assign vld[0]  = in_vld;
  assign val[0]  = in_val;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < R_W; k++) begin : g_step
    logic [REM_W-1:0] cat;
    logic [REM_W-1:0] trial;
    assign cat   = {rem[k][REM_W-3:0], val[k][IN_W-1 -: 2]};
    assign trial = {root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      val[k+1]  <= val[k] << 2;
      side[k+1] <= side[k];
      if (cat >= trial) begin
        rem[k+1]  <= cat - trial;
        root[k+1] <= {root[k][R_W-2:0], 1'b1};
      end else begin
        rem[k+1]  <= cat;
        root[k+1] <= {root[k][R_W-2:0], 1'b0};
      end
    end
  end

  assign out_vld  = vld[R_W];
  assign out_root = root[R_W];
  assign out_side = side[R_W];

endmodule

// ===== rtl/core/gsdn_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdn_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// Numerator must be below den * 2^Q_W.
// ----------------------------------------------------------------------------
module gsdn_div_pipe #(
  parameter int DEN_W  = 32,
  parameter int Q_W    = 31,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  logic [DEN_W+Q_W-1:0] in_num,
  input  logic [DEN_W-1:0]     in_den,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_vld,
  output logic [Q_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]    out_side
);

  logic              vld  [Q_W+1];
  logic [DEN_W:0]    rem  [Q_W+1];
  logic [Q_W-1:0]    lo   [Q_W+1];
  logic [DEN_W-1:0]  den  [Q_W+1];
  logic [SIDE_W-1:0] side [Q_W+1];

  assign vld[0]  = in_vld;
  assign rem[0]  = {1'b0, in_num[DEN_W+Q_W-1:Q_W]};
  assign lo[0]   = in_num[Q_W-1:0];
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W:0] cat;
    assign cat = {rem[k][DEN_W-1:0], lo[k][Q_W-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      den[k+1]  <= den[k];
      side[k+1] <= side[k];
      if (cat >= {1'b0, den[k]}) begin
        rem[k+1] <= cat - {1'b0, den[k]};
        lo[k+1]  <= {lo[k][Q_W-2:0], 1'b1};
      end else begin
        rem[k+1] <= cat;
        lo[k+1]  <= {lo[k][Q_W-2:0], 1'b0};
      end
    end
  end

  assign out_vld  = vld[Q_W];
  assign out_quo  = lo[Q_W];
  assign out_side = side[Q_W];

endmodule

// ===== rtl/core/gsdn_dir.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdn_dir
// One direction component: floor(|c| * 32768 / sqrt(s)) with the sign of c,
// done as isqrt((c^2 << 30) / s).
// ----------------------------------------------------------------------------
module gsdn_dir
  import gsdn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [30:0]        sq,      // c squared
  input  logic [31:0]        s,       // x^2 + y^2
  input  logic               neg,
  input  logic               s_zero,
  output logic               out_vld,
  output logic signed [15:0] dir
);

  logic        dv_vld;
  logic [30:0] dv_quo;
  logic [1:0]  dv_side;

  gsdn_div_pipe #(.DEN_W(32), .Q_W(31), .SIDE_W(2)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (in_vld),
    .in_num   ({2'b00, sq, 30'd0}),
    .in_den   (s),
    .in_side  ({neg, s_zero}),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  logic        m_vld;
  logic [30:0] m_quo;
  logic        m_neg;

  // zero stick forces a zero quotient, so the root and direction are zero
  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= dv_vld;
    end
    m_quo <= dv_side[0] ? 31'd0 : dv_quo;
    m_neg <= dv_side[1];
  end

  logic        sq_vld;
  logic [15:0] sq_root;
  logic        sq_neg;

  gsdn_sqrt_pipe #(.IN_W(32), .SIDE_W(1)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (m_vld),
    .in_val   ({1'b0, m_quo}),
    .in_side  (m_neg),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_neg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= sq_vld;
    end
    if (sq_neg) begin
      dir <= 16'(16'd0 - sq_root);
    end else if (sq_root > 16'd32767) begin
      dir <= 16'sd32767;
    end else begin
      dir <= sq_root;
    end
  end

endmodule

// ===== rtl/core/gsdn_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdn_lane
// One stick plus its trigger: magnitude with radial dead zone and the
// two direction components.
// ----------------------------------------------------------------------------
module gsdn_lane
  import gsdn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic [14:0]        dz,
  input  logic [7:0]         trig,
  output logic               out_vld,
  output lane_out_t          out
);

  // stage A: capture request
  logic               a_vld;
  logic signed [15:0] a_x, a_y;
  logic [14:0]        a_dz;
  logic [15:0]        a_trig;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_vld;
    end
    a_x    <= x;
    a_y    <= y;
    a_dz   <= dz;
    a_trig <= {trig, trig};  // trig * 257
  end

  // stage B: squares
  logic [15:0] ax_a, ay_a;
  assign ax_a = a_x[15] ? 16'(-a_x) : 16'(a_x);
  assign ay_a = a_y[15] ? 16'(-a_y) : 16'(a_y);

  logic        b_vld;
  logic [31:0] b_ax2, b_ay2;
  logic [29:0] b_dz2;
  logic        b_sx, b_sy;
  logic [14:0] b_dz;
  logic [15:0] b_trig;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_ax2  <= 32'(ax_a) * 32'(ax_a);
    b_ay2  <= 32'(ay_a) * 32'(ay_a);
    b_dz2  <= 30'(a_dz) * 30'(a_dz);
    b_sx   <= a_x[15];
    b_sy   <= a_y[15];
    b_dz   <= a_dz;
    b_trig <= a_trig;
  end

  // stage C: sum of squares and range flags
  logic [31:0] s_b;
  assign s_b = b_ax2 + b_ay2;

  logic        c_vld;
  logic [31:0] c_s;
  logic        c_dead, c_full, c_dzmax, c_szero;
  logic [30:0] c_ax2, c_ay2;
  logic        c_sx, c_sy;
  logic [14:0] c_dz;
  logic [15:0] c_trig;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_s     <= s_b;
    c_dead  <= s_b <= {2'b00, b_dz2};
    c_full  <= s_b >= FULL_SQ;
    c_dzmax <= b_dz == FULL_SCALE;
    c_szero <= s_b == 32'd0;
    c_ax2   <= b_ax2[30:0];
    c_ay2   <= b_ay2[30:0];
    c_sx    <= b_sx;
    c_sy    <= b_sy;
    c_dz    <= b_dz;
    c_trig  <= b_trig;
  end

  // magnitude: r = isqrt(s << 30)
  logic        mr_vld;
  logic [30:0] mr_root;
  logic [33:0] mr_side;

  gsdn_sqrt_pipe #(.IN_W(62), .SIDE_W(34)) u_mag_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (c_vld),
    .in_val   ({c_s[31:0], 30'd0}),
    .in_side  ({c_dead, c_dzmax, c_full, c_dz, c_trig}),
    .out_vld  (mr_vld),
    .out_root (mr_root),
    .out_side (mr_side)
  );

  // stage D: strip the dead zone; garbage inside the dead zone is masked later
  logic        d_vld;
  logic [29:0] d_num;
  logic [14:0] d_range;
  logic [18:0] d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= mr_vld;
    end
    d_num   <= 30'(mr_root - {1'b0, mr_side[30:16], 15'd0});
    d_range <= FULL_SCALE - mr_side[30:16];
    d_side  <= {mr_side[33:31], mr_side[15:0]};
  end

  logic        md_vld;
  logic [15:0] md_quo;
  logic [18:0] md_side;

  gsdn_div_pipe #(.DEN_W(15), .Q_W(16), .SIDE_W(19)) u_mag_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (d_vld),
    .in_num   ({1'b0, d_num}),
    .in_den   (d_range),
    .in_side  (d_side),
    .out_vld  (md_vld),
    .out_quo  (md_quo),
    .out_side (md_side)
  );

  // stage E: magnitude select
  logic [15:0] e_mag;
  logic [15:0] e_trig;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= md_vld;
    end
    e_trig <= md_side[15:0];
    if (md_side[18] || md_side[17]) begin
      e_mag <= 16'd0;
    end else if (md_side[16]) begin
      e_mag <= ONE_Q15;
    end else begin
      e_mag <= md_quo;
    end
  end

  // direction components
  logic               dx_vld, dy_vld;
  logic signed [15:0] dx, dy;

  gsdn_dir u_dir_x (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (c_vld),
    .sq      (c_ax2),
    .s       (c_s),
    .neg     (c_sx),
    .s_zero  (c_szero),
    .out_vld (dx_vld),
    .dir     (dx)
  );

  gsdn_dir u_dir_y (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (c_vld),
    .sq      (c_ay2),
    .s       (c_s),
    .neg     (c_sy),
    .s_zero  (c_szero),
    .out_vld (dy_vld),
    .dir     (dy)
  );

  assign out.mag       = e_mag;
  assign out.dir_x     = dx;
  assign out.dir_y     = dy;
  assign out.trig_norm = e_trig;

  a_dir_aligned : assert property (@(posedge clk) disable iff (rst)
    (dx_vld == out_vld) && (dy_vld == out_vld))
    else $error("direction path out of step with magnitude path");

  a_mag_range : assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (e_mag <= ONE_Q15))
    else $error("magnitude above full scale");

  a_live_dir : assert property (@(posedge clk) disable iff (rst)
    (out_vld && (e_mag != 16'd0)) |-> ((dx != 16'sd0) || (dy != 16'sd0)))
    else $error("stick outside dead zone with zero direction");

endmodule

// ===== dv/tb_gamepad_stick_deadzone_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gamepad_stick_deadzone_normalizer
// Drives gamepad samples through the dead-zone normalizer and checks every
// result against an integer model of stick magnitude, direction and trigger
// scaling, over several dead-zone settings including both extremes.
// ----------------------------------------------------------------------------
module tb_gamepad_stick_deadzone_normalizer;
  import gsdn_pkg::*;

  localparam int LATENCY = 53;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  sample_t     sample;
  logic        done;
  result_t     result;
  logic        wr_en;
  logic [0:0]  wr_index;
  logic [14:0] wr_data;

  gamepad_stick_deadzone_normalizer uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  sample_t     pending_samples[$];
  result_t     expected_results[$];
  logic [14:0] left_dz;
  logic [14:0] right_dz;
  int          error_count;
  int          cycle_count;
  logic        sending;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] scaled_mag(longint unsigned sq, logic [14:0] dz);
    longint unsigned d;
    longint unsigned q;
    d = dz;
    if (sq <= d * d || dz == FULL_SCALE) return 16'd0;
    if (sq >= 64'd32767 * 64'd32767) return ONE_Q15;
    q = (int_sqrt(sq << 30) - d * 32768) / (64'd32767 - d);
    return (q > 32768) ? ONE_Q15 : q[15:0];
  endfunction

  // floor(|c| * 32768 / sqrt(sq)) by bisection, sign of c restored
  function automatic logic [15:0] unit_dir(logic signed [15:0] c, longint unsigned sq);
    longint unsigned a;
    longint unsigned rhs;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (sq == 0) return 16'd0;
    a = (c < 0) ? -longint'(c) : longint'(c);
    rhs = (a * a) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid * sq <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (c < 0) return 16'(-lo);
    if (lo > 32767) lo = 32767;
    return lo[15:0];
  endfunction

  function automatic result_t normalize(sample_t s);
    result_t r;
    longint unsigned lsq;
    longint unsigned rsq;
    lsq = longint'(s.left_x) * s.left_x + longint'(s.left_y) * s.left_y;
    rsq = longint'(s.right_x) * s.right_x + longint'(s.right_y) * s.right_y;
    r.left_mag = scaled_mag(lsq, left_dz);
    r.left_dir_x = unit_dir(s.left_x, lsq);
    r.left_dir_y = unit_dir(s.left_y, lsq);
    r.right_mag = scaled_mag(rsq, right_dz);
    r.right_dir_x = unit_dir(s.right_x, rsq);
    r.right_dir_y = unit_dir(s.right_y, rsq);
    r.left_trig_norm = 16'(s.left_trig * 257);
    r.right_trig_norm = 16'(s.right_trig * 257);
    return r;
  endfunction

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d",
             field, got, want, cycle_count);
    error_count++;
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'($signed($urandom_range(200)) - 100);
      4, 5: return 16'($signed($urandom_range(20000)) - 10000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.left_x = rand_coord();
    s.left_y = rand_coord();
    s.right_x = rand_coord();
    s.right_y = rand_coord();
    s.left_trig = 8'($urandom);
    s.right_trig = 8'($urandom);
    return s;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(3) != 0) return 0;
    if ($urandom_range(9) != 0) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // busy as seen at the last rising edge
  logic busy_q;
  always @(posedge clk) busy_q <= busy;

  // driver
  int idle_left;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_q) begin
      // request taken at the last edge
      if (pending_samples.size() > 0 && idle_left == 0 && sending) begin
        sample <= pending_samples.pop_front();
        idle_left = rand_gap();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && sending && pending_samples.size() > 0) begin
      if (idle_left > 0) idle_left--;
      else begin
        sample <= pending_samples.pop_front();
        start <= 1'b1;
        idle_left = rand_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && start && !busy) expected_results.push_back(normalize(sample));
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_count);
        error_count++;
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (result.left_mag !== e.left_mag) report("left_mag", result.left_mag, e.left_mag);
        if (result.left_dir_x !== e.left_dir_x)
          report("left_dir_x", result.left_dir_x, e.left_dir_x);
        if (result.left_dir_y !== e.left_dir_y)
          report("left_dir_y", result.left_dir_y, e.left_dir_y);
        if (result.right_mag !== e.right_mag)
          report("right_mag", result.right_mag, e.right_mag);
        if (result.right_dir_x !== e.right_dir_x)
          report("right_dir_x", result.right_dir_x, e.right_dir_x);
        if (result.right_dir_y !== e.right_dir_y)
          report("right_dir_y", result.right_dir_y, e.right_dir_y);
        if (result.left_trig_norm !== e.left_trig_norm)
          report("left_trig_norm", result.left_trig_norm, e.left_trig_norm);
        if (result.right_trig_norm !== e.right_trig_norm)
          report("right_trig_norm", result.right_trig_norm, e.right_trig_norm);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_deadzone(logic [0:0] idx, logic [14:0] value);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == REG_LEFT_DZ) left_dz = value;
    else right_dz = value;
  endtask

  task automatic add(logic signed [15:0] lx, logic signed [15:0] ly,
                     logic signed [15:0] rx, logic signed [15:0] ry,
                     logic [7:0] lt, logic [7:0] rt);
    sample_t s;
    s = '{lx, ly, rx, ry, lt, rt};
    pending_samples.push_back(s);
  endtask

  // runs the queue dry, then waits out the pipeline
  task automatic drain();
    sending = 1'b1;
    wait (pending_samples.size() == 0);
    @(negedge clk);
    @(negedge clk);
    sending = 1'b0;
    wait (expected_results.size() == 0);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  initial begin
    logic [14:0] left_set[6];
    logic [14:0] right_set[6];
    rst = 1'b1;
    start = 1'b0;
    sample = '0;
    wr_en = 1'b0;
    wr_index = REG_LEFT_DZ;
    wr_data = '0;
    error_count = 0;
    cycle_count = 0;
    idle_left = 0;
    sending = 1'b0;
    left_dz = LEFT_DZ_RST;
    right_dz = RIGHT_DZ_RST;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed: reset dead zones, zero stick, corners, axes, trigger extremes
    add(0, 0, 0, 0, 8'd0, 8'd255);
    add(-32768, -32768, 32767, 32767, 8'd255, 8'd0);
    add(32767, 0, 0, -32768, 8'd1, 8'd128);
    add(0, 32767, -32768, 0, 8'd127, 8'd254);
    add(7849, 0, 0, 8689, 8'd0, 8'd0);
    add(7850, 0, 0, 8690, 8'd0, 8'd0);
    add(-5550, 5550, 6144, -6144, 8'd10, 8'd20);
    add(100, -100, -1, 1, 8'd85, 8'd170);
    add(23170, 23170, -23170, 23171, 8'd255, 8'd255);
    drain();

    // no dead zone on the left stick, full dead zone on the right stick
    write_deadzone(REG_LEFT_DZ, 15'd0);
    write_deadzone(REG_RIGHT_DZ, 15'd32767);
    add(1, 0, 1, 0, 8'd0, 8'd0);
    add(0, 0, 32767, 32767, 8'd0, 8'd0);
    add(-32768, 0, -32768, -32768, 8'd0, 8'd0);
    add(16384, -12000, 100, 200, 8'd3, 8'd4);
    drain();

    left_set = '{15'd32766, 15'd1, 15'd4000, 15'd0, 15'd32767, 15'd20000};
    right_set = '{15'd0, 15'd32766, 15'd12000, 15'd100, 15'd1, 15'd32767};
    for (int p = 0; p < 6; p++) begin
      write_deadzone(REG_LEFT_DZ, left_set[p]);
      write_deadzone(REG_RIGHT_DZ, right_set[p]);
      for (int i = 0; i < 250; i++) pending_samples.push_back(rand_sample());
      drain();
    end

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
